/* src/gait_phase_scheduler_defines.svh */
// Assertion macros shared by the gait phase scheduler checker.
// Expects signals named clock and reset in the scope of each use.
`ifndef GAIT_PHASE_SCHEDULER_DEFINES_SVH
`define GAIT_PHASE_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define GPS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define GPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/gps_pkg.sv */
// Shared constants, types and helper functions for the gait phase scheduler.
// No dependencies; imported by every module of the block.
package gps_pkg;

   // Sizing
   localparam int MAX_PHASES     = 8;
   localparam int LEGS           = 4;
   localparam int TICK_W         = 31;
   localparam int DUR_W          = 16;
   localparam int PHASES_W       = 4;
   localparam int TABLE_W        = 32;
   localparam int MASK_W         = LEGS;
   localparam int PHASE_W        = $clog2(MAX_PHASES);
   localparam int NCNT_W         = $clog2(MAX_PHASES + 1);
   localparam int TOTAL_W        = $clog2(MAX_PHASES * (2 ** DUR_W - 1) + 1);

   // Modulo pipeline: tick bits retired per stage
   localparam int BITS_PER_STAGE = 4;
   localparam int DIV_STAGES     = (TICK_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
   localparam int PAD_W          = DIV_STAGES * BITS_PER_STAGE;

   // Register port
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_STANCE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SWING  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_PHASES = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE  = CSR_IDX_W'(3);

   typedef logic [TOTAL_W-1:0] total_type;
   typedef logic [MASK_W-1:0]  mask_type;
   typedef logic [DUR_W-1:0]   dur_type;

   localparam dur_type                 STANCE_RST = DUR_W'(1);
   localparam dur_type                 SWING_RST  = DUR_W'(1);
   localparam logic [PHASES_W-1:0]     PHASES_RST = PHASES_W'(4);
   localparam logic [TABLE_W-1:0]      TABLE_RST  = '1;
   localparam mask_type                ALL_LEGS   = '1;

   // Schedule derived from the registers, shared by the datapath
   typedef struct packed {
      total_type                             total;
      logic                                  total_zero;
      logic [PHASE_W-1:0]                    last;
      logic [MAX_PHASES-1:0][TOTAL_W-1:0]    bound;
      logic [MAX_PHASES-1:0][TOTAL_W-1:0]    start;
      logic [MAX_PHASES-1:0][MASK_W-1:0]     mask;
   } sched_type;

   // Leg mask of one phase; slots beyond the table read as all legs lifted
   function automatic mask_type phase_mask(logic [TABLE_W-1:0] ctab, int unsigned phase);
      logic [TABLE_W-1:0] shifted;
      if (phase * LEGS >= TABLE_W) begin
         return '0;
      end
      shifted = ctab >> (phase * LEGS);
      return shifted[MASK_W-1:0];
   endfunction

   // One restoring step: shift in a tick bit, subtract the cycle length if it fits
   function automatic total_type rem_step(total_type rem, logic bit_in, total_type total);
      logic [TOTAL_W:0] cat;
      logic [TOTAL_W:0] diff;
      cat  = {rem, bit_in};
      diff = cat - {1'b0, total};
      if (cat >= {1'b0, total}) begin
         return diff[TOTAL_W-1:0];
      end
      return cat[TOTAL_W-1:0];
   endfunction

endpackage

/* src/gait_phase_scheduler.sv */
// Gait phase scheduler: maps a controller tick to the active gait phase.
// Channels: req_ carries one tick count per item; rsp_ returns the phase
// index, the ticks elapsed within that phase and the phase's leg contact
// mask, one result per item, in order. csr_ writes the stance duration,
// swing duration, phase count and contact table (index 0 to 3); csr_ready
// is always high.
// The modulo by the cycle length runs through 8 restoring stages of 4
// tick bits each, after an input stage; a compare stage and a select
// stage follow. Throughput: one item per clock while rsp_ready does not
// stall the output, so up to 11 items are in flight.
// Stalls: each stage holds while its successor is full and stalled, so
// bubbles close up and req_ready falls only once every stage is occupied.
// Registers take effect for items accepted from the cycle after the write.
// Reset: registers return to stance 1, swing 1, four phases, all legs in
// contact; all stages are emptied.
// Depends on gps_pkg, gps_cfg, gps_div and gps_locate.
module gait_phase_scheduler (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [gps_pkg::TICK_W-1:0]     req_tick_count,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [gps_pkg::PHASE_W-1:0]    rsp_phase_number,
   output logic [gps_pkg::DUR_W-1:0]      rsp_ticks_into_phase,
   output logic [gps_pkg::MASK_W-1:0]     rsp_leg_contacts,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [gps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gps_pkg::CSR_DATA_W-1:0] csr_data
);
   import gps_pkg::*;

   sched_type sched;
   logic      div_valid;
   logic      div_ready;
   total_type div_pos;

   // Registers and derived schedule
   gps_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .sched     (sched)
   );

   // Reduce the tick modulo the cycle length
   gps_div u_div (
      .clock     (clock),
      .reset     (reset),
      .total     (sched.total),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_tick   (req_tick_count),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_pos   (div_pos)
   );

   // Find the phase and drive the result register
   gps_locate u_locate (
      .clock     (clock),
      .reset     (reset),
      .sched     (sched),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_pos    (div_pos),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_phase (rsp_phase_number),
      .out_into  (rsp_ticks_into_phase),
      .out_mask  (rsp_leg_contacts)
   );

endmodule

/* src/gps_cfg.sv */
// Register file and schedule derivation: phase durations, cycle length,
// phase boundaries and leg masks. Depends on gps_pkg.
module gps_cfg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [gps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gps_pkg::CSR_DATA_W-1:0] csr_data,
   output gps_pkg::sched_type             sched
);
   import gps_pkg::*;

   dur_type                            stance_ff, stance_in;
   dur_type                            swing_ff, swing_in;
   logic [PHASES_W-1:0]                phases_ff, phases_in;
   logic [TABLE_W-1:0]                 table_ff, table_in;

   logic [NCNT_W-1:0]                  count_c;
   logic [MAX_PHASES-1:0][MASK_W-1:0]  mask_in, mask_ff;
   logic [MAX_PHASES-1:0][DUR_W-1:0]   dur_in, dur_ff;
   total_type                          total_in, total_ff;
   logic [PHASE_W-1:0]                 last_in, last_ff;
   logic [MAX_PHASES-1:0][TOTAL_W-1:0] bound_in, bound_ff;
   logic [MAX_PHASES-1:0][TOTAL_W-1:0] start_in, start_ff;
   total_type                          acc;

   assign csr_ready = 1'b1;

   // Register writes
   always_comb begin
      stance_in = stance_ff;
      swing_in  = swing_ff;
      phases_in = phases_ff;
      table_in  = table_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_STANCE: stance_in = csr_data[DUR_W-1:0];
            CSR_SWING:  swing_in  = csr_data[DUR_W-1:0];
            CSR_PHASES: phases_in = csr_data[PHASES_W-1:0];
            CSR_TABLE:  table_in  = csr_data[TABLE_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stance_ff <= STANCE_RST;
         swing_ff  <= SWING_RST;
         phases_ff <= PHASES_RST;
         table_ff  <= TABLE_RST;
      end else begin
         stance_ff <= stance_in;
         swing_ff  <= swing_in;
         phases_ff <= phases_in;
         table_ff  <= table_in;
      end
   end

   // Clamp the phase count, pick each phase's duration, sum the cycle length
   always_comb begin
      if (phases_ff == '0) begin
         count_c = NCNT_W'(1);
      end else if (32'(phases_ff) > MAX_PHASES) begin
         count_c = NCNT_W'(MAX_PHASES);
      end else begin
         count_c = NCNT_W'(phases_ff);
      end
      last_in  = PHASE_W'(count_c - NCNT_W'(1));
      total_in = '0;
      for (int i = 0; i < MAX_PHASES; i++) begin
         mask_in[i] = phase_mask(table_ff, i);
         if (i < 32'(count_c)) begin
            dur_in[i] = (mask_in[i] == ALL_LEGS) ? stance_ff : swing_ff;
         end else begin
            dur_in[i] = '0;
         end
         total_in = total_in + TOTAL_W'(dur_in[i]);
      end
   end

   // Running boundaries: start and end of each phase in the cycle
   always_comb begin
      acc = '0;
      for (int i = 0; i < MAX_PHASES; i++) begin
         start_in[i] = acc;
         acc         = acc + TOTAL_W'(dur_ff[i]);
         bound_in[i] = acc;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff  <= mask_in;
      dur_ff   <= dur_in;
      total_ff <= total_in;
      last_ff  <= last_in;
      bound_ff <= bound_in;
      start_ff <= start_in;
   end

   always_comb begin
      sched.total      = total_ff;
      sched.total_zero = (total_ff == '0);
      sched.last       = last_ff;
      sched.bound      = bound_ff;
      sched.start      = start_ff;
      sched.mask       = mask_ff;
   end

endmodule

/* src/gps_div.sv */
// Pipelined restoring modulo: tick count reduced by the cycle length,
// a few tick bits retired per stage. Depends on gps_pkg.
module gps_div (
   input  logic                        clock,
   input  logic                        reset,
   input  gps_pkg::total_type          total,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [gps_pkg::TICK_W-1:0]  in_tick,
   output logic                        out_valid,
   input  logic                        out_ready,
   output gps_pkg::total_type          out_pos
);
   import gps_pkg::*;

   logic [DIV_STAGES:0]   vld_ff, vld_in;
   logic [DIV_STAGES+1:0] rdy;
   logic [PAD_W-1:0]      tick_ff [DIV_STAGES];
   logic [PAD_W-1:0]      tick_in [DIV_STAGES];
   total_type             rem_ff  [DIV_STAGES+1];
   total_type             rem_in  [DIV_STAGES+1];
   total_type             step_r;

   // A stage takes new data when it is empty or its successor moves on
   always_comb begin
      rdy[DIV_STAGES+1] = out_ready;
      for (int k = DIV_STAGES; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[DIV_STAGES];
   assign out_pos   = rem_ff[DIV_STAGES];

   // Advance valid bits
   always_comb begin
      vld_in[0] = rdy[0] ? in_valid : vld_ff[0];
      for (int k = 1; k <= DIV_STAGES; k++) begin
         vld_in[k] = rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   // Retire BITS_PER_STAGE tick bits per stage, most significant first
   always_comb begin
      tick_in[0] = PAD_W'(in_tick);
      rem_in[0]  = '0;
      for (int k = 1; k < DIV_STAGES; k++) begin
         tick_in[k] = tick_ff[k-1];
      end
      for (int k = 1; k <= DIV_STAGES; k++) begin
         step_r = rem_ff[k-1];
         for (int j = 0; j < BITS_PER_STAGE; j++) begin
            step_r = rem_step(step_r, tick_ff[k-1][PAD_W-1-(k-1)*BITS_PER_STAGE-j], total);
         end
         rem_in[k] = step_r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (rdy[k]) begin
            tick_ff[k] <= tick_in[k];
         end
      end
      for (int k = 0; k <= DIV_STAGES; k++) begin
         if (rdy[k]) begin
            rem_ff[k] <= rem_in[k];
         end
      end
   end

endmodule

/* src/gps_locate.sv */
// Phase search: compares the reduced tick with every phase boundary, then
// picks the first phase that ends beyond it. Depends on gps_pkg.
module gps_locate (
   input  logic                         clock,
   input  logic                         reset,
   input  gps_pkg::sched_type           sched,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  gps_pkg::total_type           in_pos,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [gps_pkg::PHASE_W-1:0]  out_phase,
   output logic [gps_pkg::DUR_W-1:0]    out_into,
   output gps_pkg::mask_type            out_mask
);
   import gps_pkg::*;

   logic                   rdy_a, rdy_b;
   logic                   vld_a_ff, vld_a_in;
   logic                   vld_b_ff, vld_b_in;
   total_type              pos_a_ff;
   logic [MAX_PHASES-1:0]  less_a_ff, less_a_in;
   logic [PHASE_W-1:0]     phase_b_ff, phase_b_in;
   logic [DUR_W-1:0]       into_b_ff, into_b_in;
   mask_type               mask_b_ff, mask_b_in;
   logic                   found;
   total_type              into_c;

   assign rdy_b    = !vld_b_ff || out_ready;
   assign rdy_a    = !vld_a_ff || rdy_b;
   assign in_ready = rdy_a;

   assign vld_a_in = rdy_a ? in_valid : vld_a_ff;
   assign vld_b_in = rdy_b ? vld_a_ff : vld_b_ff;

   // Stage A: compare against each phase end
   always_comb begin
      for (int i = 0; i < MAX_PHASES; i++) begin
         less_a_in[i] = (in_pos < sched.bound[i]);
      end
   end

   // Stage B: take the first phase ending past the position
   always_comb begin
      found      = 1'b0;
      phase_b_in = sched.last;
      for (int i = 0; i < MAX_PHASES; i++) begin
         if (!found && less_a_ff[i]) begin
            found      = 1'b1;
            phase_b_in = PHASE_W'(i);
         end
      end
      into_c = pos_a_ff - sched.start[phase_b_in];
      if (sched.total_zero) begin
         phase_b_in = sched.last;
         into_b_in  = '0;
      end else begin
         into_b_in  = into_c[DUR_W-1:0];
      end
      mask_b_in = sched.mask[phase_b_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else begin
         vld_a_ff <= vld_a_in;
         vld_b_ff <= vld_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a) begin
         pos_a_ff  <= in_pos;
         less_a_ff <= less_a_in;
      end
      if (rdy_b) begin
         phase_b_ff <= phase_b_in;
         into_b_ff  <= into_b_in;
         mask_b_ff  <= mask_b_in;
      end
   end

   assign out_valid = vld_b_ff;
   assign out_phase = phase_b_ff;
   assign out_into  = into_b_ff;
   assign out_mask  = mask_b_ff;

endmodule

/* src/gps_checker.sv */
// Port-level checks for the gait phase scheduler, bound to the top level.
// Depends on gps_pkg and gait_phase_scheduler_defines.svh.
`include "gait_phase_scheduler_defines.svh"

module gps_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic [gps_pkg::TICK_W-1:0]     req_tick_count,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [gps_pkg::PHASE_W-1:0]    rsp_phase_number,
   input logic [gps_pkg::DUR_W-1:0]      rsp_ticks_into_phase,
   input logic [gps_pkg::MASK_W-1:0]     rsp_leg_contacts,
   input logic                           csr_valid,
   input logic                           csr_ready,
   input logic [gps_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [gps_pkg::CSR_DATA_W-1:0] csr_data
);
   import gps_pkg::*;

   logic [NCNT_W-1:0]   count_ff, count_in;
   logic [PHASES_W-1:0] wr_phases;

   // Track the clamped phase count from register writes
   assign wr_phases = csr_data[PHASES_W-1:0];

   always_comb begin
      count_in = count_ff;
      if (csr_valid && csr_ready && csr_index == CSR_PHASES) begin
         if (wr_phases == '0) begin
            count_in = NCNT_W'(1);
         end else if (32'(wr_phases) > MAX_PHASES) begin
            count_in = NCNT_W'(MAX_PHASES);
         end else begin
            count_in = NCNT_W'(wr_phases);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= NCNT_W'(PHASES_RST);
      end else begin
         count_ff <= count_in;
      end
   end

   // A stalled result holds its value
   `GPS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_phase_number) && $stable(rsp_ticks_into_phase) && $stable(rsp_leg_contacts), "stalled result changed")

   // Reset empties the pipeline
   `GPS_ASSERT_IMPL(a_reset_empty, $past(reset), !rsp_valid, "result valid right after reset")

   // With no result pending every stage can move, so the input is ready
   `GPS_ASSERT_IMPL(a_ready_drained, !rsp_valid, req_ready, "input stalled with output empty")

   // The reported phase is one of the phases in use
   `GPS_ASSERT_IMPL(a_phase_in_use, rsp_valid, NCNT_W'(rsp_phase_number) < count_ff, "phase out of range")

endmodule

bind gait_phase_scheduler gps_checker u_checker (.*);
